FILE: hdl/fec_pkg.sv
// Shared types and constants for the fade envelope controller.
package fec_pkg;

    localparam logic [16:0] Q_ONE         = 17'h10000;
    localparam logic [15:0] PUNCH_MIN_DIV = 16'd10;
    localparam logic [16:0] WAIT_MAX      = 17'h1FFFF;
    localparam logic [47:0] OPAC_ROUND    = 48'h0000_8000_0000;
    localparam logic [35:0] OFF_ROUND     = 36'h0_0000_8000;

    localparam int unsigned DIV_ITERS = 8;
    localparam int unsigned DIV_CNT_W = 3;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;

    localparam logic [2:0] REG_FADE_IN      = 3'd0;
    localparam logic [2:0] REG_FADE_OUT     = 3'd1;
    localparam logic [2:0] REG_APPEAR_DELAY = 3'd2;
    localparam logic [2:0] REG_HOLD         = 3'd3;
    localparam logic [2:0] REG_PUNCH_LEVEL  = 3'd4;
    localparam logic [2:0] REG_RISE         = 3'd5;

    localparam logic [15:0] FADE_IN_RST      = 16'd250;
    localparam logic [15:0] FADE_OUT_RST     = 16'd250;
    localparam logic [15:0] APPEAR_DELAY_RST = 16'd0;
    localparam logic [15:0] HOLD_RST         = 16'd0;
    localparam logic [16:0] PUNCH_LEVEL_RST  = 17'd0;
    localparam logic [9:0]  RISE_RST         = 10'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE,
        ST_PDIV,
        ST_PWAIT,
        ST_MAIN,
        ST_SWAIT,
        ST_MSQ,
        ST_MLO,
        ST_MHI,
        ST_OPAC,
        ST_MOFF,
        ST_OUT
    } fec_state_t;

    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_LO,
        MUL_HI,
        MUL_OFF
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     pre;
        logic     div_start;
        logic     div_punch;
        logic     punch_apply;
        logic     main;
        logic     step_apply;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     opac_load;
        logic     out_load;
    } fec_cmd_t;

    typedef struct packed {
        logic punch_nz;
        logic need_step;
        logic div_done;
        logic out_free;
    } fec_status_t;

endpackage

FILE: hdl/fade_envelope_controller.sv
// Top level of the fade envelope controller: one result per tick.
// A tick runs through the controller states in turn, with a punch-decay division and a
// progress-step division only when the tick needs them; a new tick is taken only in idle.
// The shared radix-4 divider and the shared 18x18 multiplier are used in turn. A waiting
// result does not block input.
// Reset (aresetn low, synchronous) restores register defaults and clears the envelope.
module fade_envelope_controller (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_wanted,
    input  logic                             s_content_changed,
    input  logic [15:0]                      s_elapsed_ms,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [16:0]                      m_opacity,
    output logic [9:0]                       m_offset_pixels,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fec_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fec_pkg::CFG_DATA_W-1:0]   cfg_data
);

    fec_pkg::fec_cmd_t    cmd;
    fec_pkg::fec_status_t status;

    assign cfg_ready = 1'b1;

    fec_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    fec_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_wanted          (s_wanted),
        .s_content_changed (s_content_changed),
        .s_elapsed_ms      (s_elapsed_ms),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_opacity         (m_opacity),
        .m_offset_pixels   (m_offset_pixels),
        .cmd               (cmd),
        .status            (status)
    );

endmodule

FILE: hdl/fec_div.sv
// Iterative Q16 fraction divider, two quotient bits per cycle, saturating at one.
module fec_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [16:0] quotient
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [fec_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [15:0]                    rem_reg, rem_next;
    logic [15:0]                    dvs_reg, dvs_next;
    logic [16:0]                    quo_reg, quo_next;
    logic [15:0]                    iter_rem;
    logic [1:0]                     iter_bits;

    always_comb begin : iter_blk
        logic [16:0] trial;
        logic [15:0] r;
        r = rem_reg;
        iter_bits = 2'b00;
        for (int i = 0; i < 2; i++) begin
            trial = {r, 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                iter_bits[1-i] = 1'b1;
                r = 16'(trial - {1'b0, dvs_reg});
            end else begin
                r = trial[15:0];
            end
        end
        iter_rem = r;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start) begin
            dvs_next = divisor;
            cnt_next = '0;
            if (dividend >= divisor) begin
                quo_next  = fec_pkg::Q_ONE;
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                rem_next  = dividend;
                quo_next  = '0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = iter_rem;
            quo_next = {quo_reg[14:0], iter_bits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == fec_pkg::DIV_CNT_W'(fec_pkg::DIV_ITERS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hdl/fec_dp.sv
// Datapath: configuration, envelope state, shared divider and multiplier, result register.
module fec_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [fec_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fec_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_wanted,
    input  logic                             s_content_changed,
    input  logic [15:0]                      s_elapsed_ms,
    input  logic                             m_ready,
    output logic                             m_valid,
    output logic [16:0]                      m_opacity,
    output logic [9:0]                       m_offset_pixels,
    input  fec_pkg::fec_cmd_t                cmd,
    output fec_pkg::fec_status_t             status
);

    logic [15:0] fade_in_reg, fade_out_reg, appear_delay_reg, hold_ms_reg;
    logic [16:0] punch_level_reg;
    logic [9:0]  rise_reg;

    logic        wanted_reg, changed_reg;
    logic [15:0] elapsed_reg;

    logic [16:0] progress_reg, progress_next;
    logic [16:0] appear_wait_reg, appear_wait_next;
    logic [15:0] hold_left_reg, hold_left_next;
    logic [16:0] punch_reg, punch_next;

    logic [35:0] prod_reg;
    logic [35:0] acc_reg;
    logic [15:0] sq_hi_reg;
    logic [16:0] opac_reg;

    logic        m_valid_reg, m_valid_next;
    logic [16:0] opacity_out_reg;
    logic [9:0]  offset_out_reg;

    logic [15:0] punch_div, step_div, div_divisor;
    logic        div_done;
    logic [16:0] div_q;

    logic        prog_zero, wait_short;
    logic [17:0] wait_sum, prog_sum;
    logic [17:0] smooth_k;
    logic [17:0] total_raw;
    logic [16:0] total;
    logic [17:0] mul_a, mul_b;
    logic [35:0] mul_p;
    logic [52:0] opac_sum;
    logic [35:0] off_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_in_reg      <= fec_pkg::FADE_IN_RST;
            fade_out_reg     <= fec_pkg::FADE_OUT_RST;
            appear_delay_reg <= fec_pkg::APPEAR_DELAY_RST;
            hold_ms_reg      <= fec_pkg::HOLD_RST;
            punch_level_reg  <= fec_pkg::PUNCH_LEVEL_RST;
            rise_reg         <= fec_pkg::RISE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                fec_pkg::REG_FADE_IN:      fade_in_reg      <= cfg_data[15:0];
                fec_pkg::REG_FADE_OUT:     fade_out_reg     <= cfg_data[15:0];
                fec_pkg::REG_APPEAR_DELAY: appear_delay_reg <= cfg_data[15:0];
                fec_pkg::REG_HOLD:         hold_ms_reg      <= cfg_data[15:0];
                fec_pkg::REG_PUNCH_LEVEL:  punch_level_reg  <= cfg_data;
                fec_pkg::REG_RISE:         rise_reg         <= cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            wanted_reg  <= s_wanted;
            changed_reg <= s_content_changed;
            elapsed_reg <= s_elapsed_ms;
        end
    end

    assign punch_div   = (fade_in_reg < fec_pkg::PUNCH_MIN_DIV) ? fec_pkg::PUNCH_MIN_DIV
                                                              : fade_in_reg;
    assign step_div    = wanted_reg ? fade_in_reg : fade_out_reg;
    assign div_divisor = cmd.div_punch ? punch_div : step_div;

    fec_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (elapsed_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign prog_zero  = (progress_reg == '0);
    assign wait_short = (appear_wait_reg < {1'b0, appear_delay_reg});
    assign wait_sum   = {1'b0, appear_wait_reg} + {2'b00, elapsed_reg};
    assign prog_sum   = {1'b0, progress_reg} + {1'b0, div_q};

    always_comb begin
        progress_next    = progress_reg;
        appear_wait_next = appear_wait_reg;
        hold_left_next   = hold_left_reg;
        punch_next       = punch_reg;
        if (cmd.pre) begin
            if (wanted_reg && changed_reg && prog_zero) begin
                appear_wait_next = '0;
            end
            if (wanted_reg) begin
                if (changed_reg && !prog_zero) begin
                    punch_next = (punch_level_reg > fec_pkg::Q_ONE) ? fec_pkg::Q_ONE
                                                                   : punch_level_reg;
                end
                hold_left_next = hold_ms_reg;
            end
        end
        if (cmd.punch_apply) begin
            punch_next = (div_q >= punch_reg) ? '0 : punch_reg - div_q;
        end
        if (cmd.main) begin
            if (wanted_reg) begin
                if (!prog_zero) begin
                    appear_wait_next = {1'b0, appear_delay_reg};
                end else if (wait_short) begin
                    appear_wait_next = (wait_sum > {1'b0, fec_pkg::WAIT_MAX})
                                     ? fec_pkg::WAIT_MAX : wait_sum[16:0];
                end
            end else begin
                appear_wait_next = '0;
                if (hold_left_reg != '0) begin
                    hold_left_next = (elapsed_reg >= hold_left_reg) ? '0
                                                                    : hold_left_reg - elapsed_reg;
                end
            end
        end
        if (cmd.step_apply) begin
            if (wanted_reg) begin
                progress_next = (prog_sum > {1'b0, fec_pkg::Q_ONE}) ? fec_pkg::Q_ONE
                                                                    : prog_sum[16:0];
            end else if (div_q >= progress_reg) begin
                progress_next = '0;
                punch_next    = '0;
            end else begin
                progress_next = progress_reg - div_q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            progress_reg    <= '0;
            appear_wait_reg <= '0;
            hold_left_reg   <= '0;
            punch_reg       <= '0;
        end else begin
            progress_reg    <= progress_next;
            appear_wait_reg <= appear_wait_next;
            hold_left_reg   <= hold_left_next;
            punch_reg       <= punch_next;
        end
    end

    // Smoothstep is p*p*(3 - 2p); the square is split into two partial products.
    assign smooth_k  = 18'({1'b0, fec_pkg::Q_ONE} + {1'b0, fec_pkg::Q_ONE}
                           + {1'b0, fec_pkg::Q_ONE}) - {progress_reg, 1'b0};
    assign total_raw = {1'b0, fec_pkg::Q_ONE} - {1'b0, opac_reg} + {1'b0, punch_reg};
    assign total     = (total_raw > {1'b0, fec_pkg::Q_ONE}) ? fec_pkg::Q_ONE : total_raw[16:0];

    always_comb begin
        case (cmd.mul_sel)
            fec_pkg::MUL_SQ: begin
                mul_a = {1'b0, progress_reg};
                mul_b = {1'b0, progress_reg};
            end
            fec_pkg::MUL_LO: begin
                mul_a = {1'b0, prod_reg[16:0]};
                mul_b = smooth_k;
            end
            fec_pkg::MUL_HI: begin
                mul_a = {2'b00, sq_hi_reg};
                mul_b = smooth_k;
            end
            fec_pkg::MUL_OFF: begin
                mul_a = {1'b0, total};
                mul_b = {8'd0, rise_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign opac_sum = {prod_reg, 17'd0} + {17'd0, acc_reg} + {5'd0, fec_pkg::OPAC_ROUND};
    assign off_sum  = prod_reg + fec_pkg::OFF_ROUND;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= mul_p;
            if (cmd.mul_sel == fec_pkg::MUL_LO) begin
                sq_hi_reg <= prod_reg[32:17];
            end
            if (cmd.mul_sel == fec_pkg::MUL_HI) begin
                acc_reg <= prod_reg;
            end
        end
        if (cmd.opac_load) begin
            opac_reg <= opac_sum[48:32];
        end
        if (cmd.out_load) begin
            opacity_out_reg <= opac_reg;
            offset_out_reg  <= off_sum[25:16];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_opacity       = opacity_out_reg;
    assign m_offset_pixels = offset_out_reg;

    assign status.punch_nz  = (punch_reg != '0);
    assign status.need_step = wanted_reg ? !(prog_zero && wait_short) : (hold_left_reg == '0);
    assign status.div_done  = div_done;
    assign status.out_free  = !m_valid_reg || m_ready;

    a_progress_range: assert property (@(posedge aclk) disable iff (!aresetn)
        progress_reg <= fec_pkg::Q_ONE)
        else $error("progress above one");

    a_punch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        punch_reg <= fec_pkg::Q_ONE)
        else $error("punch above one");

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before transfer");

    a_punch_cleared_at_rest: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step_apply && !wanted_reg) |=> (progress_reg != '0 || punch_reg == '0))
        else $error("punch left after fade out reached zero");

endmodule

FILE: hdl/fec_ctrl.sv
// Controller state machine sequencing one tick through the datapath.
module fec_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output fec_pkg::fec_cmd_t     cmd,
    input  fec_pkg::fec_status_t  status
);

    fec_pkg::fec_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fec_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = fec_pkg::ST_PRE;
                end
            end
            fec_pkg::ST_PRE: state_next = fec_pkg::ST_PDIV;
            fec_pkg::ST_PDIV: begin
                state_next = status.punch_nz ? fec_pkg::ST_PWAIT : fec_pkg::ST_MAIN;
            end
            fec_pkg::ST_PWAIT: begin
                if (status.div_done) begin
                    state_next = fec_pkg::ST_MAIN;
                end
            end
            fec_pkg::ST_MAIN: begin
                state_next = status.need_step ? fec_pkg::ST_SWAIT : fec_pkg::ST_MSQ;
            end
            fec_pkg::ST_SWAIT: begin
                if (status.div_done) begin
                    state_next = fec_pkg::ST_MSQ;
                end
            end
            fec_pkg::ST_MSQ:  state_next = fec_pkg::ST_MLO;
            fec_pkg::ST_MLO:  state_next = fec_pkg::ST_MHI;
            fec_pkg::ST_MHI:  state_next = fec_pkg::ST_OPAC;
            fec_pkg::ST_OPAC: state_next = fec_pkg::ST_MOFF;
            fec_pkg::ST_MOFF: state_next = fec_pkg::ST_OUT;
            fec_pkg::ST_OUT: begin
                if (status.out_free) begin
                    state_next = fec_pkg::ST_IDLE;
                end
            end
            default: state_next = fec_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        case (state_reg)
            fec_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            fec_pkg::ST_PRE: cmd.pre = 1'b1;
            fec_pkg::ST_PDIV: begin
                cmd.div_start = status.punch_nz;
                cmd.div_punch = 1'b1;
            end
            fec_pkg::ST_PWAIT: cmd.punch_apply = status.div_done;
            fec_pkg::ST_MAIN: begin
                cmd.main      = 1'b1;
                cmd.div_start = status.need_step;
            end
            fec_pkg::ST_SWAIT: cmd.step_apply = status.div_done;
            fec_pkg::ST_MSQ: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = fec_pkg::MUL_SQ;
            end
            fec_pkg::ST_MLO: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = fec_pkg::MUL_LO;
            end
            fec_pkg::ST_MHI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = fec_pkg::MUL_HI;
            end
            fec_pkg::ST_OPAC: cmd.opac_load = 1'b1;
            fec_pkg::ST_MOFF: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = fec_pkg::MUL_OFF;
            end
            fec_pkg::ST_OUT: cmd.out_load = status.out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fec_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
